// ----- hw/rtl/fcd_pkg.sv -----
// Shared types and constants for the flash command decoder.
package fcd_pkg;

  localparam int unsigned ADDR_W    = 21;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned LEN_W     = 17;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [ADDR_W-1:0] UNLOCK_ADDR1 = 21'h005555;
  localparam logic [ADDR_W-1:0] UNLOCK_ADDR2 = 21'h002AAA;
  localparam logic [ADDR_W-1:0] BOOT_BASE    = 21'h1F0000;
  localparam logic [ADDR_W-1:0] MASK_64K     = 21'h1F0000;
  localparam logic [ADDR_W-1:0] MASK_32K     = 21'h1F8000;
  localparam logic [ADDR_W-1:0] MASK_16K     = 21'h1FC000;
  localparam logic [ADDR_W-1:0] MASK_8K      = 21'h1FE000;

  localparam logic [LEN_W-1:0] LEN_64K = 17'h10000;
  localparam logic [LEN_W-1:0] LEN_32K = 17'h08000;
  localparam logic [LEN_W-1:0] LEN_16K = 17'h04000;
  localparam logic [LEN_W-1:0] LEN_8K  = 17'h02000;

  localparam logic [DATA_W-1:0] DAT_UNLOCK1  = 8'hAA;
  localparam logic [DATA_W-1:0] DAT_UNLOCK2  = 8'h55;
  localparam logic [DATA_W-1:0] CMD_ERASE_GO = 8'h30;
  localparam logic [DATA_W-1:0] CMD_ERASE_SU = 8'h80;
  localparam logic [DATA_W-1:0] CMD_ID       = 8'h90;
  localparam logic [DATA_W-1:0] CMD_PROTECT  = 8'h9A;
  localparam logic [DATA_W-1:0] CMD_PROGRAM  = 8'hA0;

  typedef enum logic [2:0] {
    ST_READ    = 3'd0,
    ST_UNLOCK1 = 3'd1,
    ST_UNLOCK2 = 3'd2,
    ST_CMD     = 3'd3,
    ST_ID      = 3'd4,
    ST_PROGRAM = 3'd5,
    ST_ERASE   = 3'd6,
    ST_PROTECT = 3'd7
  } seq_state_t;

  typedef enum logic [1:0] {
    PC_NONE    = 2'd0,
    PC_ERASE   = 2'd1,
    PC_PROTECT = 2'd2
  } pend_cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_PROGRAM = 2'd1,
    ACT_ERASE   = 2'd2,
    ACT_SHOWID  = 2'd3
  } action_t;

  // Lowest field last: action sits in the low bits.
  typedef struct packed {
    logic              restore_ids;
    logic [DATA_W-1:0] program_byte;
    logic [LEN_W-1:0]  erase_bytes;
    logic [ADDR_W-1:0] target_addr;
    action_t           action;
  } result_t;

  typedef struct packed {
    seq_state_t seq;
    pend_cmd_t  pend;
  } ctl_state_t;

endpackage

// ----- hw/rtl/fcd_decode.sv -----
// Command sequence decode: next state and action for one bus write.
module fcd_decode (
  input  fcd_pkg::ctl_state_t           cur_i,
  input  logic [fcd_pkg::ADDR_W-1:0]    offset_i,
  input  logic [fcd_pkg::DATA_W-1:0]    wdata_i,
  output fcd_pkg::ctl_state_t           nxt_o,
  output fcd_pkg::result_t              res_o
);
  import fcd_pkg::*;

  logic       unlock_hit;
  seq_state_t seq_nxt;
  pend_cmd_t  pend_nxt;

  assign unlock_hit = (offset_i == UNLOCK_ADDR1) && (wdata_i == DAT_UNLOCK1);

  // Next state
  always_comb begin
    seq_nxt  = ST_READ;
    pend_nxt = cur_i.pend;
    unique case (cur_i.seq)
      ST_READ: begin
        seq_nxt  = unlock_hit ? ST_UNLOCK1 : ST_READ;
        pend_nxt = PC_NONE;
      end
      ST_UNLOCK1: begin
        seq_nxt = ((offset_i == UNLOCK_ADDR2) && (wdata_i == DAT_UNLOCK2)) ?
                  ST_UNLOCK2 : ST_READ;
      end
      ST_UNLOCK2: begin
        priority if (wdata_i == CMD_ERASE_GO) begin
          seq_nxt = (cur_i.pend == PC_ERASE) ? ST_ERASE : ST_READ;
        end else if (offset_i != UNLOCK_ADDR1) begin
          seq_nxt = ST_READ;
        end else if (wdata_i == CMD_ERASE_SU) begin
          seq_nxt  = ST_CMD;
          pend_nxt = PC_ERASE;
        end else if (wdata_i == CMD_ID) begin
          seq_nxt = ST_ID;
        end else if (wdata_i == CMD_PROTECT) begin
          if (cur_i.pend == PC_PROTECT) begin
            seq_nxt = ST_PROTECT;
          end else begin
            seq_nxt  = ST_CMD;
            pend_nxt = PC_PROTECT;
          end
        end else if (wdata_i == CMD_PROGRAM) begin
          seq_nxt = ST_PROGRAM;
        end else begin
          seq_nxt = ST_READ;
        end
      end
      ST_CMD: begin
        seq_nxt = unlock_hit ? ST_UNLOCK1 : ST_READ;
      end
      ST_ID: begin
        seq_nxt  = unlock_hit ? ST_UNLOCK1 : ST_READ;
        pend_nxt = PC_NONE;
      end
      ST_PROGRAM, ST_ERASE, ST_PROTECT: begin
        seq_nxt = ST_READ;
      end
      default: begin
        seq_nxt = ST_READ;
      end
    endcase
    // Back in read: drop any half-entered command
    if (seq_nxt == ST_READ) begin
      pend_nxt = PC_NONE;
    end
  end

  assign nxt_o.seq  = seq_nxt;
  assign nxt_o.pend = pend_nxt;

  // Outputs
  always_comb begin
    res_o              = '0;
    res_o.action       = ACT_NONE;
    res_o.restore_ids  = (seq_nxt == ST_READ);
    unique case (cur_i.seq)
      ST_UNLOCK2: begin
        priority if ((wdata_i == CMD_ERASE_GO) && (cur_i.pend == PC_ERASE)) begin
          res_o.action = ACT_ERASE;
          // Boot sectors in the top 64 KiB split into 32K/8K/8K/16K
          priority if (offset_i < BOOT_BASE) begin
            res_o.target_addr = offset_i & MASK_64K;
            res_o.erase_bytes = LEN_64K;
          end else if (!offset_i[15]) begin
            res_o.target_addr = offset_i & MASK_32K;
            res_o.erase_bytes = LEN_32K;
          end else if (!offset_i[14]) begin
            res_o.target_addr = offset_i & MASK_8K;
            res_o.erase_bytes = LEN_8K;
          end else begin
            res_o.target_addr = offset_i & MASK_16K;
            res_o.erase_bytes = LEN_16K;
          end
        end else if ((wdata_i == CMD_ID) && (offset_i == UNLOCK_ADDR1)) begin
          res_o.action = ACT_SHOWID;
        end else begin
          res_o.action = ACT_NONE;
        end
      end
      ST_PROGRAM: begin
        res_o.action       = ACT_PROGRAM;
        res_o.target_addr  = offset_i;
        res_o.program_byte = wdata_i;
      end
      default: begin
        res_o.action = ACT_NONE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/flash_command_decoder.sv -----
// Top level of the flash command decoder: stream ports, state and result buffering.
// A result beat is registered in the output register, or in the skid while out_* stalls.
// Throughput: one write per cycle while in_tready is high; the decode is a single
// pass through fcd_decode between the sequence state register and the result register.
// A two-entry result buffer (output register plus skid) keeps in_tready high while
// one result waits on a stalled consumer.
// Reset (rst_n low, synchronous): sequence goes to read, no pending command, buffer empty.
module flash_command_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fcd_pkg::IN_TDATA_W-1:0]     in_tdata,   // [20:0] offset, [28:21] wdata
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fcd_pkg::OUT_TDATA_W-1:0]    out_tdata   // [1:0] action, [22:2] target_addr,
                                                         // [39:23] erase_bytes,
                                                         // [47:40] program_byte,
                                                         // [48] restore_ids
);
  import fcd_pkg::*;

  ctl_state_t ctl_r, ctl_nxt;
  result_t    dec_res;
  result_t    out_res_r, skid_res_r;
  logic       out_valid_r, skid_valid_r;
  logic       in_beat, out_beat;

  logic [ADDR_W-1:0] in_offset;
  logic [DATA_W-1:0] in_wdata;

  assign in_offset = in_tdata[ADDR_W-1:0];
  assign in_wdata  = in_tdata[ADDR_W+DATA_W-1:ADDR_W];

  // Accept whenever the skid slot is free; that always leaves room for this beat.
  assign in_tready = !skid_valid_r;
  assign in_beat   = in_tvalid && in_tready;
  assign out_beat  = out_valid_r && out_tready;

  fcd_decode u_decode (
    .cur_i    (ctl_r),
    .offset_i (in_offset),
    .wdata_i  (in_wdata),
    .nxt_o    (ctl_nxt),
    .res_o    (dec_res)
  );

  // Advance the command sequence on every accepted write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.seq  <= ST_READ;
      ctl_r.pend <= PC_NONE;
    end else if (in_beat) begin
      ctl_r <= ctl_nxt;
    end
  end

  // Result buffer: output register in front, skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_tready) begin
        // Output slot frees up: refill from skid first, else from the new beat
        out_valid_r  <= skid_valid_r || in_beat;
        skid_valid_r <= skid_valid_r ? 1'b0 : 1'b0;
      end else if (in_beat) begin
        // Output stalled: park the new result in the skid
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else if (in_beat) begin
        out_res_r <= dec_res;
      end
    end
    if (in_beat) begin
      skid_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_res_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Skid only fills behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  // Every erase decision leaves the sequencer in the erase state
  a_erase_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (dec_res.action == ACT_ERASE)) |=> (ctl_r.seq == ST_ERASE))
    else $error("erase issued without entering the erase state");

  // In read state nothing may be left pending
  a_read_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.seq == ST_READ) |-> (ctl_r.pend == PC_NONE))
    else $error("pending command survived a return to read");

  // A beat accepted while the output stalls lands in the skid
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("result lost while output was stalled");

endmodule
